@@ rtl/core/mlft_pkg.sv @@
`default_nettype none

package mlft_pkg;

    // Field widths fixed by the item formats
    localparam int MAC_W  = 48;
    localparam int PORT_W = 4;
    localparam int MASK_W = 16;
    localparam int CFG_W  = 5;
    // Wide enough to hold any port-count limit
    localparam int CNT_W  = 7;

    // Group (multicast/broadcast) flag position in a MAC address
    localparam int GROUP_BIT = 40;

    localparam logic [CFG_W-1:0] ACTIVE_PORTS_RST = CFG_W'(4);

    typedef struct packed {
        logic [PORT_W-1:0] ingress_port;
        logic [MAC_W-1:0]  dest_mac;
        logic [MAC_W-1:0]  src_mac;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] egress_mask;
        logic              flooded;
        logic              filtered;
        logic              learned_new;
        logic              table_full;
    } out_item_t;

    // One stored table entry
    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } entry_t;

    // Compare unit results for one entry
    typedef struct packed {
        logic src_hit;
        logic dst_hit;
    } match_t;

    // Ports 0 .. n-1 minus the ingress port
    function automatic logic [MASK_W-1:0] flood_mask(
        input logic [CNT_W-1:0]  n,
        input logic [PORT_W-1:0] ingress
    );
        logic [MASK_W-1:0] m;
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (CNT_W'(i) < n);
        end
        m[ingress] = 1'b0;
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mac_learning_forward_table.sv @@
`default_nettype none

// Learning MAC forwarding table. Each item (ingress port, destination MAC,
// source MAC) first learns the source into the lowest free entry, then looks
// up the destination and returns one result: a one-hot egress mask for a
// known unicast destination, a flood mask over ports 0..active_ports-1 (at
// most MAX_PORTS) minus the ingress port for unknown or group destinations,
// or a filtered drop when the destination lives on the ingress port. Entries
// are never removed, so occupied entries are always 0..N-1 and a fill count
// stands in for valid bits; reset empties the table at once. The table is
// one RAM with one write and one read port, scanned one entry per cycle
// through a shared compare unit (N = entries in use, at most TABLE_ENTRIES);
// the result then waits until the output register is free. The next item can
// be accepted in the cycle after the result is loaded. in_ready is low while
// an item is in work. active_ports is written through cfg_wen/cfg_wdata; the
// user must do so only while the block is idle, which it does not enforce.
module mac_learning_forward_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int MAX_PORTS     = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wen,
    input  wire logic [mlft_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire mlft_pkg::in_item_t         in_item,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output mlft_pkg::out_item_t             out_item
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);
    localparam logic [mlft_pkg::CNT_W-1:0] MAXP = mlft_pkg::CNT_W'(MAX_PORTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_LEARN = 2'd2;

    logic [1:0]                       state_reg, state_next;
    mlft_pkg::in_item_t               item_reg;
    logic [CW-1:0]                    idx_reg, idx_next;
    logic                             pend_reg, pend_next;
    logic                             src_hit_reg, src_hit_next;
    logic                             dst_hit_reg, dst_hit_next;
    logic [mlft_pkg::PORT_W-1:0]      dst_port_reg, dst_port_next;
    logic [CW-1:0]                    fill_reg, fill_next;
    logic [mlft_pkg::CFG_W-1:0]       act_reg;
    logic                             out_valid_reg, out_valid_next;
    mlft_pkg::out_item_t              out_item_reg;

    logic                             in_acc;
    logic                             rd_en;
    logic                             done;
    logic                             do_learn;
    mlft_pkg::entry_t                 rd_entry;
    mlft_pkg::entry_t                 wr_entry;
    mlft_pkg::match_t                 hit;
    mlft_pkg::out_item_t              result;

    // Result computation
    logic                             src_new;
    logic                             room;
    logic                             self_hit;
    logic                             known;
    logic [mlft_pkg::PORT_W-1:0]      known_port;
    logic [mlft_pkg::CNT_W-1:0]       act_ext;
    logic [mlft_pkg::CNT_W-1:0]       flood_n;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Scan reads entries 0 .. fill-1
    assign rd_en = (state_reg == S_SCAN) && (idx_reg < fill_reg);
    assign done  = (state_reg == S_LEARN) && (!out_valid_reg || out_ready);

    mlft_table #(
        .ENTRIES (TABLE_ENTRIES),
        .AW      (AW)
    ) u_table (
        .clk   (clk),
        .we    (do_learn),
        .waddr (fill_reg[AW-1:0]),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_entry)
    );

    mlft_match u_match (
        .vld      (pend_reg),
        .entry    (rd_entry),
        .src_mac  (item_reg.src_mac),
        .dest_mac (item_reg.dest_mac),
        .hit      (hit)
    );

    // Learn and lookup decision
    always_comb
    begin
        src_new    = !src_hit_reg;
        room       = (fill_reg < FULL_CNT);
        do_learn   = done && src_new && room;
        self_hit   = src_new && room && (item_reg.dest_mac == item_reg.src_mac);
        known      = !item_reg.dest_mac[mlft_pkg::GROUP_BIT] && (dst_hit_reg || self_hit);
        known_port = dst_hit_reg ? dst_port_reg : item_reg.ingress_port;
        act_ext    = mlft_pkg::CNT_W'(act_reg);
        flood_n    = (act_ext > MAXP) ? MAXP : act_ext;

        wr_entry.mac  = item_reg.src_mac;
        wr_entry.port = item_reg.ingress_port;

        result.learned_new = src_new && room;
        result.table_full  = src_new && !room;
        result.flooded     = 1'b0;
        result.filtered    = 1'b0;
        if (!known)
        begin
            result.flooded     = 1'b1;
            result.egress_mask = mlft_pkg::flood_mask(flood_n, item_reg.ingress_port);
        end
        else if (known_port == item_reg.ingress_port)
        begin
            result.filtered    = 1'b1;
            result.egress_mask = '0;
        end
        else
        begin
            result.egress_mask = mlft_pkg::MASK_W'(1) << known_port;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        src_hit_next   = src_hit_reg;
        dst_hit_next   = dst_hit_reg;
        dst_port_next  = dst_port_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next     = '0;
                    src_hit_next = 1'b0;
                    dst_hit_next = 1'b0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                pend_next = rd_en;
                if (rd_en)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (hit.src_hit)
                begin
                    src_hit_next = 1'b1;
                end
                if (hit.dst_hit)
                begin
                    dst_hit_next  = 1'b1;
                    dst_port_next = rd_entry.port;
                end
                if (!rd_en && !pend_reg)
                begin
                    state_next = S_LEARN;
                end
            end
            S_LEARN:
            begin
                if (done)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (do_learn)
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            src_hit_reg   <= 1'b0;
            dst_hit_reg   <= 1'b0;
            fill_reg      <= '0;
            act_reg       <= mlft_pkg::ACTIVE_PORTS_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            src_hit_reg   <= src_hit_next;
            dst_hit_reg   <= dst_hit_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                act_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        dst_port_reg <= dst_port_next;
        if (in_acc)
        begin
            item_reg <= in_item;
        end
        if (done)
        begin
            out_item_reg <= result;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mlft_table.sv @@
`default_nettype none

module mlft_table #(
    parameter int ENTRIES = 64,
    parameter int AW      = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire mlft_pkg::entry_t  wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output mlft_pkg::entry_t       rdata
);

    mlft_pkg::entry_t mem [ENTRIES];
    mlft_pkg::entry_t rdata_reg;

    // Single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Single read port, registered data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/mlft_match.sv @@
`default_nettype none

module mlft_match (
    input  wire logic                       vld,
    input  wire mlft_pkg::entry_t           entry,
    input  wire logic [mlft_pkg::MAC_W-1:0] src_mac,
    input  wire logic [mlft_pkg::MAC_W-1:0] dest_mac,
    output mlft_pkg::match_t                hit
);

    // Compare one stored entry against both keys of the item
    always_comb
    begin
        hit.src_hit = vld && (entry.mac == src_mac);
        hit.dst_hit = vld && (entry.mac == dest_mac);
    end

endmodule

`default_nettype wire

@@ rtl/core/mlft_checker.sv @@
`default_nettype none

module mlft_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire mlft_pkg::out_item_t        out_item
);

    // Busy after taking an item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after an item was accepted");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result changed or dropped");

    // Flood and filter are exclusive, filter means empty mask
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.flooded && out_item.filtered)
                      && (!out_item.filtered || out_item.egress_mask == '0))
        else $error("inconsistent forwarding flags");

    // A source is either inserted or rejected, not both
    a_learn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.learned_new && out_item.table_full))
        else $error("learned_new and table_full both set");

endmodule

bind mac_learning_forward_table mlft_checker u_chk (.*);

`default_nettype wire

@@ tb/sv/mac_learning_forward_table_test.sv @@
`timescale 1ns / 1ps

module mac_learning_forward_table_test;

    import mlft_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int MAX_PORT_COUNT = 16;
    localparam logic [MAC_W-1:0] BCAST_MAC = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wen;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_item;

    // Shadow copy of the forwarding table and the port-count register
    logic [MAC_W-1:0]     tbl_mac  [TABLE_DEPTH];
    logic [PORT_W-1:0]    tbl_port [TABLE_DEPTH];
    int                   mac_count;
    logic [CFG_W-1:0]     port_count;

    // Forwarding decisions still owed by the block, oldest first
    out_item_t            pending_decisions [$];

    bit                   idling;
    int                   errors;
    int                   frames_sent;
    int                   n_flood, n_unicast, n_filter, n_learned, n_full, n_cfg;

    mac_learning_forward_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    // Table search over the learned entries
    function automatic int find_mac(input logic [MAC_W-1:0] mac);
        for (int i = 0; i < mac_count; i++) begin
            if (tbl_mac[i] == mac)
                return i;
        end
        return -1;
    endfunction

    // Learn the source, then forward on the destination
    function automatic out_item_t forward_frame(input in_item_t f);
        out_item_t         r;
        int                dst_at;
        int                n;
        logic [MASK_W-1:0] ports;
        r = '0;
        if (find_mac(f.src_mac) < 0) begin
            if (mac_count < TABLE_DEPTH) begin
                tbl_mac[mac_count]  = f.src_mac;
                tbl_port[mac_count] = f.ingress_port;
                mac_count++;
                r.learned_new = 1'b1;
            end
            else begin
                r.table_full = 1'b1;
            end
        end
        dst_at = f.dest_mac[GROUP_BIT] ? -1 : find_mac(f.dest_mac);
        if (dst_at < 0) begin
            n = (int'(port_count) > MAX_PORT_COUNT) ? MAX_PORT_COUNT : int'(port_count);
            ports = MASK_W'((32'd1 << n) - 32'd1);
            ports[f.ingress_port] = 1'b0;
            r.egress_mask = ports;
            r.flooded = 1'b1;
        end
        else if (tbl_port[dst_at] == f.ingress_port) begin
            r.filtered = 1'b1;
        end
        else begin
            r.egress_mask = MASK_W'(1) << tbl_port[dst_at];
        end
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] any_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly well-formed traffic: learned addresses with some noise
    function automatic in_item_t random_frame(input int fresh_pct);
        in_item_t f;
        int       idx;
        int       pick;
        f.ingress_port = PORT_W'($urandom_range(0, 15));
        if (mac_count == 0 || $urandom_range(0, 99) < fresh_pct)
            f.src_mac = any_mac();
        else
            f.src_mac = tbl_mac[$urandom_range(0, mac_count - 1)];
        pick = $urandom_range(0, 9);
        if (mac_count == 0)
            pick = 8;
        idx = $urandom_range(0, (mac_count > 0) ? mac_count - 1 : 0);
        case (pick)
            0, 1, 2, 3, 4: f.dest_mac = tbl_mac[idx];
            5, 6:
            begin
                // destination sits on the ingress port: drop
                f.dest_mac = tbl_mac[idx];
                f.ingress_port = tbl_port[idx];
            end
            7: f.dest_mac = BCAST_MAC;
            8: f.dest_mac = any_mac();
            default: f.dest_mac = f.src_mac;
        endcase
        return f;
    endfunction

    // Offer one item and record its expected decision on acceptance
    task automatic send_frame(input in_item_t f);
        int gap;
        if (idling && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= f;
        do @(posedge clk); while (!in_ready);
        pending_decisions.insert(pending_decisions.size(), forward_frame(f));
        frames_sent++;
    endtask

    task automatic send_fields(input int port, input logic [MAC_W-1:0] dst,
                               input logic [MAC_W-1:0] src);
        in_item_t f;
        f.ingress_port = PORT_W'(port);
        f.dest_mac     = dst;
        f.src_mac      = src;
        send_frame(f);
    endtask

    // Stop offering and wait for every owed decision
    task automatic go_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_decisions.size() != 0) @(negedge clk);
    endtask

    task automatic set_active_ports(input logic [CFG_W-1:0] v);
        go_quiet();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wen    <= 1'b0;
        port_count = v;
        n_cfg++;
    endtask

    // Field edges and the corner cases, at the reset port count
    task automatic check_directed_cases();
        idling = 1'b0;
        send_fields(0, BCAST_MAC, 48'h0);                         // flood from port 0
        send_fields(15, 48'h0, BCAST_MAC);                        // ingress past active
        send_fields(3, BCAST_MAC, 48'h01005E000001);              // group source learned
        send_fields(5, 48'h01005E000001, 48'h000000000002);       // group dest floods
        send_fields(7, 48'h0A0B0C0D0E0F, 48'h0A0B0C0D0E0F);       // learn then filter
        send_fields(2, 48'h000000000002, 48'h000000000003);       // known port past active
        send_fields(0, 48'h0, 48'h000000000003);                  // dest on ingress: drop
        send_fields(6, 48'h0, 48'h0);                             // known source not moved
        send_fields(1, 48'h0, 48'hAAAAAAAAAAAA);
        send_fields(12, 48'h020000000001, 48'h555555555555);      // unknown unicast
        send_fields(9, 48'hFEFFFFFFFFFF, 48'hFEFFFFFFFFFF);
        send_fields(4, 48'hAAAAAAAAAAAA, 48'h123456789ABC);
        send_fields(10, 48'h555555555555, 48'hFFFFFFFFFFFE);
        send_fields(15, BCAST_MAC, 48'h800000000000);
    endtask

    // Flood width across port counts, extremes included
    task automatic check_port_counts();
        logic [CFG_W-1:0] counts [8];
        counts = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd16, 5'd17, 5'd31, 5'($urandom_range(4, 15))};
        idling = 1'b1;
        foreach (counts[i]) begin
            set_active_ports(counts[i]);
            send_fields(0, BCAST_MAC, 48'h0);
            send_fields(15, any_mac() & ~(48'h1 << GROUP_BIT), BCAST_MAC);
            send_fields($urandom_range(0, 15), BCAST_MAC, 48'hAAAAAAAAAAAA);
            send_frame(random_frame(20));
        end
    endtask

    // Learn until the table runs out, then offer new sources
    task automatic check_table_fill();
        in_item_t f;
        set_active_ports(5'd8);
        idling = 1'b1;
        while (mac_count < TABLE_DEPTH)
            send_frame(random_frame(80));
        for (int i = 0; i < 6; i++) begin
            f = random_frame(0);
            f.src_mac = any_mac();
            send_frame(f);
        end
    endtask

    // Long mixed traffic over several port counts
    task automatic check_random_traffic();
        logic [CFG_W-1:0] v;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: v = 5'($urandom_range(2, 16));
                1: v = 5'd16;
                2: v = 5'd2;
                3: v = 5'($urandom_range(17, 31));
                4: v = 5'd1;
                default: v = 5'($urandom_range(0, 31));
            endcase
            set_active_ports(v);
            for (int i = 0; i < 215; i++) begin
                idling = (ph != 5) && (i < 150);
                if (ph == 2 && i == 100)
                    go_quiet();
                send_frame(random_frame(15));
            end
        end
    endtask

    // Result side backpressure
    always begin
        @(negedge clk);
        if (rst_n && idling && $urandom_range(0, 5) == 0) begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        out_ready <= 1'b1;
    end

    // Compare each delivered item with the oldest owed decision
    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_decisions.size() == 0) begin
                errors++;
                $display("%0t: unexpected result mask=%h fl=%b fi=%b ln=%b tf=%b", $time,
                         out_item.egress_mask, out_item.flooded, out_item.filtered,
                         out_item.learned_new, out_item.table_full);
            end
            else begin
                want = pending_decisions.pop_front();
                if (out_item.egress_mask !== want.egress_mask ||
                    out_item.flooded !== want.flooded ||
                    out_item.filtered !== want.filtered ||
                    out_item.learned_new !== want.learned_new ||
                    out_item.table_full !== want.table_full) begin
                    errors++;
                    $display("%0t: mismatch expected mask=%h fl=%b fi=%b ln=%b tf=%b, %s",
                             $time, want.egress_mask, want.flooded, want.filtered,
                             want.learned_new, want.table_full,
                             $sformatf("got mask=%h fl=%b fi=%b ln=%b tf=%b",
                                       out_item.egress_mask, out_item.flooded,
                                       out_item.filtered, out_item.learned_new,
                                       out_item.table_full));
                end
                if (want.flooded)
                    n_flood++;
                else if (want.filtered)
                    n_filter++;
                else
                    n_unicast++;
                n_learned += want.learned_new;
                n_full    += want.table_full;
            end
        end
    end

    // Watchdog
    initial begin
        #30_000_000;
        $display("mac_learning_forward_table_test failed");
        $finish;
    end

    initial begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_wen    = 1'b0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        in_item    = '0;
        out_ready  = 1'b0;
        idling     = 1'b0;
        mac_count  = 0;
        port_count = ACTIVE_PORTS_RST;
        errors     = 0;
        frames_sent = 0;
        n_flood = 0; n_unicast = 0; n_filter = 0; n_learned = 0; n_full = 0; n_cfg = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_directed_cases();
        check_port_counts();
        check_table_fill();
        check_random_traffic();

        // drain, then allow a full table scan for stray results
        go_quiet();
        repeat (TABLE_DEPTH + 16) @(posedge clk);

        $display("covered %0d frames over %0d port-count writes: %0d flooded, %0d unicast,",
                 frames_sent, n_cfg, n_flood, n_unicast);
        $display("  %0d filtered, %0d sources learned, %0d refused on a full table",
                 n_filter, n_learned, n_full);
        if (errors == 0)
            $display("mac_learning_forward_table_test passed");
        else
            $display("mac_learning_forward_table_test failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/mlft_pkg.sv
rtl/core/mlft_table.sv
rtl/core/mlft_match.sv
rtl/core/mac_learning_forward_table.sv
rtl/core/mlft_checker.sv
tb/sv/mac_learning_forward_table_test.sv
